>>> rtl/core/ctv_pkg.sv
// ----------------------------------------------------------------------------
// ctv_pkg
// Shared constants and types for the cubic trajectory velocity block.
// ----------------------------------------------------------------------------
`default_nettype none

package ctv_pkg;

    // Command codes on the input channel.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Milliseconds per second times six, used in the c2/c3 solve.
    localparam int unsigned SIX_K = 6000;

    // Width of the signed working values (magnitude saturates at 2^62).
    localparam int ACC_W = 64;

    // Request to the shift-and-add multiplier.
    typedef struct packed {
        logic        start;
        logic [63:0] mag_a;   // magnitude of the multiplicand
        logic [47:0] r;       // unsigned Q.32 multiplier, t/T up to 65535
    } ctv_mul_req_t;

    // Request to the restoring divider.
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } ctv_div_req_t;

endpackage

`default_nettype wire

>>> rtl/core/ctv_div.sv
// ----------------------------------------------------------------------------
// ctv_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ctv_div
    import ctv_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire ctv_div_req_t req,
    output logic              done,
    output logic [63:0]       quot
);

    logic [63:0] num_reg, num_next;
    logic [63:0] den_reg, den_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        shifted   = {rem_reg[63:0], num_reg[63]};
        diff      = shifted - {1'b0, den_reg};
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[62:0], 1'b0};
            if (!diff[64])
            begin
                rem_next = diff;
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

>>> rtl/core/ctv_mul.sv
// ----------------------------------------------------------------------------
// ctv_mul
// Bit-serial multiplier of a 64-bit magnitude by an unsigned Q.32 factor,
// rounded to nearest and saturated to 2^62.
// ----------------------------------------------------------------------------
`default_nettype none

module ctv_mul
    import ctv_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire ctv_mul_req_t req,
    output logic              done,
    output logic [63:0]       prod
);

    // Accumulator holds the full product; r is consumed MSB first.
    logic [111:0] acc_reg, acc_next;
    logic [63:0]  a_reg, a_next;
    logic [47:0]  r_reg, r_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [111:0] rounded;
    logic [79:0]  upper;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = '0;
            a_next    = req.mag_a;
            r_next    = req.r;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[110:0], 1'b0} + (r_reg[47] ? {48'd0, a_reg} : 112'd0);
            r_next   = {r_reg[46:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        r_reg   <= r_next;
    end

    // Round at bit 31 and saturate the result to 2^62.
    assign rounded = acc_reg + 112'h8000_0000;
    assign upper   = rounded[111:32];
    assign prod    = (upper > 80'h4000_0000_0000_0000) ? 64'h4000_0000_0000_0000
                                                       : upper[63:0];
    assign done    = done_reg;

endmodule

`default_nettype wire

>>> rtl/core/cubic_trajectory_velocity.sv
// ----------------------------------------------------------------------------
// cubic_trajectory_velocity
// Three-axis cubic trajectory planner: loads per-axis coefficients and
// evaluates the velocity of all axes at a given time.
//
//  channel | dir | handshake        | payload
//  in      | in  | valid / ready    | cmd axis start_pos start_vel end_pos
//          |     |                  | end_vel duration_ms time_ms
//  out     | out | out_valid/ready  | vel_x vel_y vel_z
//
// A load goes through the transfer, one 64-step pass of the serial
// divider and the store write.
// An evaluate runs one divide for t/T and two 48-step passes of the serial
// multiplier for each loaded axis; an unloaded or missing axis skips them.
// Axes run one after another.
// Reset clears the coefficient store at once (it is a set of registers).
// One item is in work at a time; a waiting result holds off the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_trajectory_velocity
    import ctv_pkg::*;
#(
    parameter int AXES      = 3,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid,
    output logic                    ready,
    input  wire logic               cmd,
    input  wire logic [1:0]         axis,
    input  wire logic signed [15:0] start_pos,
    input  wire logic signed [15:0] start_vel,
    input  wire logic signed [15:0] end_pos,
    input  wire logic signed [15:0] end_vel,
    input  wire logic [15:0]        duration_ms,
    input  wire logic [15:0]        time_ms,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      vel_x,
    output logic signed [31:0]      vel_y,
    output logic signed [31:0]      vel_z
);

    localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;
    localparam logic signed [63:0] SAT = 64'sh4000_0000_0000_0000;

    // Sequencer codes.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LDIV  = 4'd1;
    localparam logic [3:0] ST_EAX   = 4'd2;
    localparam logic [3:0] ST_EDIV  = 4'd3;
    localparam logic [3:0] ST_EM1   = 4'd4;
    localparam logic [3:0] ST_EM2   = 4'd5;
    localparam logic [3:0] ST_ENEXT = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;

    logic [3:0] state_reg, state_next;

    // Coefficient store, one set per axis.
    logic [15:0]        v0_reg [AXES];
    logic [15:0]        t_reg  [AXES];
    logic signed [63:0] c2_reg [AXES];
    logic signed [63:0] c3_reg [AXES];

    // Latched input item.
    logic [AX_W-1:0]    ax_reg;
    logic               ldok_reg;
    logic signed [15:0] lv0_reg, lvf_reg;
    logic [15:0]        ldur_reg;
    logic               dneg_reg;
    logic [15:0]        tm_reg;
    logic [2:0]         eix_reg;
    logic [47:0]        r_reg;
    logic signed [63:0] inner_reg;
    logic signed [31:0] vel_reg [3];

    ctv_div_req_t dreq;
    ctv_mul_req_t mreq;
    logic        ddone, mdone;
    logic [63:0] dquot, mprod;

    ctv_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dquot));
    ctv_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .done(mdone), .prod(mprod));

    logic               accept;
    logic               ax_live;
    logic signed [16:0] dpos;
    logic [16:0]        dmag;
    logic [15:0]        tfix;
    logic [AX_W-1:0]    eax;
    logic signed [63:0] mres;
    logic signed [63:0] sum;
    logic signed [63:0] clampd;
    logic signed [63:0] qs;
    logic signed [63:0] one_v0, one_vf;
    logic signed [63:0] fin;
    logic [63:0]        fmag;
    logic [63:0]        fmag2;
    logic [31:0]        fq;
    logic               fneg;

    assign ready   = (state_reg == ST_IDLE);
    assign accept  = valid && ready;
    assign dpos    = 17'(end_pos) - 17'(start_pos);
    assign dmag    = dpos[16] ? 17'(-dpos) : 17'(dpos);
    assign tfix    = (duration_ms == 16'd0) ? 16'd1 : duration_ms;
    assign eax     = eix_reg[AX_W-1:0];
    // The current output field maps to an axis that exists.
    assign ax_live = (eix_reg != 3'd3) && (32'(eix_reg) < AXES);

    // Signed view of the multiplier output for the current operand sign.
    assign mres = (state_reg == ST_EM1 ? c3_reg[eax][63] : inner_reg[63])
                  ? -$signed(mprod) : $signed(mprod);

    always_comb
    begin
        if (state_reg == ST_EM1)
            sum = c2_reg[eax] + mres;
        else
            sum = ($signed(64'(signed'(v0_reg[eax]))) <<< FRAC_BITS) + mres;
        clampd = (sum > SAT) ? SAT : ((sum < -SAT) ? -SAT : sum);
    end

    // Final rounding to Q16.16 with saturation.
    always_comb
    begin
        fin   = clampd;
        fneg  = fin[63];
        fmag  = fneg ? 64'(-fin) : 64'(fin);
        fmag2 = fmag;
        if (FRAC_BITS > 16)
            fmag2 = (fmag + (64'd1 << (FRAC_BITS - 17))) >> (FRAC_BITS - 16);
        else if (FRAC_BITS < 16)
            fmag2 = (fmag > (64'h8000_0000 >> (16 - FRAC_BITS))) ? 64'h8000_0000
                    : (fmag << (16 - FRAC_BITS));
        if (!fneg && fmag2 > 64'h7FFF_FFFF)
            fmag2 = 64'h7FFF_FFFF;
        if (fneg && fmag2 > 64'h8000_0000)
            fmag2 = 64'h8000_0000;
        fq = fneg ? 32'(-fmag2) : fmag2[31:0];
    end

    // Load results: q from the divider, then c2 and c3.
    assign qs     = dneg_reg ? -$signed(dquot) : $signed(dquot);
    assign one_v0 = $signed(64'(signed'(lv0_reg))) <<< FRAC_BITS;
    assign one_vf = $signed(64'(signed'(lvf_reg))) <<< FRAC_BITS;

    // Requests to the shared units.
    always_comb
    begin
        dreq       = '0;
        mreq       = '0;
        if (accept && cmd == CMD_LOAD)
        begin
            dreq.start = 1'b1;
            dreq.num   = ((64'(SIX_K) * 64'(dmag)) << (FRAC_BITS + 1)) + 64'(tfix);
            dreq.den   = {47'd0, tfix, 1'b0};
        end
        else if (state_reg == ST_EAX && ax_live && t_reg[eax] != 16'd0)
        begin
            dreq.start = 1'b1;
            dreq.num   = (64'(tm_reg) << 33) + 64'(t_reg[eax]);
            dreq.den   = {47'd0, t_reg[eax], 1'b0};
        end
        if (state_reg == ST_EDIV && ddone)
        begin
            mreq.start = 1'b1;
            mreq.mag_a = c3_reg[eax][63] ? 64'(-c3_reg[eax]) : 64'(c3_reg[eax]);
            mreq.r     = dquot[47:0];
        end
        else if (state_reg == ST_EM1 && mdone)
        begin
            mreq.start = 1'b1;
            mreq.mag_a = clampd[63] ? 64'(-clampd) : 64'(clampd);
            mreq.r     = r_reg;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_LOAD)
                        state_next = ST_LDIV;
                    else
                        state_next = ST_EAX;
                end
            end
            ST_LDIV:  if (ddone) state_next = ST_IDLE;
            ST_EAX:
            begin
                if (eix_reg == 3'd3)
                    state_next = ST_OUT;
                else if (!ax_live || t_reg[eax] == 16'd0)
                    state_next = ST_ENEXT;
                else
                    state_next = ST_EDIV;
            end
            ST_EDIV:  if (ddone) state_next = ST_EM1;
            ST_EM1:   if (mdone) state_next = ST_EM2;
            ST_EM2:   if (mdone) state_next = ST_ENEXT;
            ST_ENEXT: state_next = ST_EAX;
            ST_OUT:   if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < AXES; i++)
            begin
                v0_reg[i] <= '0;
                t_reg[i]  <= '0;
                c2_reg[i] <= '0;
                c3_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // A load naming an axis that does not exist leaves the store alone.
            if (state_reg == ST_LDIV && ddone && ldok_reg)
            begin
                v0_reg[ax_reg] <= lv0_reg;
                t_reg[ax_reg]  <= ldur_reg;
                c2_reg[ax_reg] <= qs - (one_v0 <<< 2) - (one_vf <<< 1);
                c3_reg[ax_reg] <= -qs + 3 * (one_v0 + one_vf);
            end
        end
    end

    // Item and per-axis working registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lv0_reg  <= start_vel;
            lvf_reg  <= end_vel;
            ldur_reg <= tfix;
            dneg_reg <= dpos[16];
            tm_reg   <= time_ms;
            eix_reg  <= '0;
            ax_reg   <= axis[AX_W-1:0];
            ldok_reg <= (32'(axis) < AXES) && (axis != 2'd3);
        end
        if (state_reg == ST_EDIV && ddone)
            r_reg <= dquot[47:0];
        if (state_reg == ST_EM1 && mdone)
            inner_reg <= clampd;
        if (state_reg == ST_EM2 && mdone)
            vel_reg[eix_reg[1:0]] <= fq;
        if (state_reg == ST_EAX && eix_reg != 3'd3 &&
            (!ax_live || t_reg[eax] == 16'd0))
            vel_reg[eix_reg[1:0]] <= !ax_live ? 32'd0
                                     : 32'(signed'(v0_reg[eax])) <<< 16;
        if (state_reg == ST_ENEXT)
            eix_reg <= eix_reg + 3'd1;
    end

    assign out_valid = (state_reg == ST_OUT);
    assign vel_x     = vel_reg[0];
    assign vel_y     = vel_reg[1];
    assign vel_z     = vel_reg[2];

    // Assertions.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !ready) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_eval_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_EAX) else $error("bad result path");

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Cubic trajectory velocity testbench
// Drives load and evaluate transfers into the block with random gaps and
// output stalls, predicts each velocity triple from a local copy of the
// per-axis cubic coefficients, and compares every result field by field.
// ----------------------------------------------------------------------------

// Expected velocity triples, in order of the evaluate transfers.
class velocity_scoreboard;
    logic signed [31:0] exp_x[$];
    logic signed [31:0] exp_y[$];
    logic signed [31:0] exp_z[$];
    int                 errors;

    function new();
        errors = 0;
    endfunction

    function void note_eval(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
        exp_x.push_back(x);
        exp_y.push_back(y);
        exp_z.push_back(z);
    endfunction

    function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z);
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
        if (exp_x.size() == 0)
        begin
            $error("result with no evaluate pending: %0d %0d %0d", x, y, z);
            errors++;
            return;
        end
        ex = exp_x.pop_front();
        ey = exp_y.pop_front();
        ez = exp_z.pop_front();
        if (x !== ex)
        begin
            $error("vel_x expected %0d actual %0d", ex, x);
            errors++;
        end
        if (y !== ey)
        begin
            $error("vel_y expected %0d actual %0d", ey, y);
            errors++;
        end
        if (z !== ez)
        begin
            $error("vel_z expected %0d actual %0d", ez, z);
            errors++;
        end
    endfunction

    function int pending();
        return exp_x.size();
    endfunction
endclass

module testbench;
    import ctv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     NUM_AXES = 3;
    localparam int     FRAC     = 16;
    localparam longint LIM62    = 64'sd1 <<< 62;

    logic               clk;
    logic               rst_n;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [1:0]         axis;
    logic signed [15:0] start_pos;
    logic signed [15:0] start_vel;
    logic signed [15:0] end_pos;
    logic signed [15:0] end_vel;
    logic [15:0]        duration_ms;
    logic [15:0]        time_ms;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;

    // Local copy of the coefficient store.
    logic signed [15:0] axis_v0[NUM_AXES];
    logic [15:0]        axis_dur[NUM_AXES];
    longint             axis_c2[NUM_AXES];
    longint             axis_c3[NUM_AXES];

    velocity_scoreboard sb;
    bit                 stim_done;
    bit                 rx_enable;

    cubic_trajectory_velocity uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (valid),
        .ready      (ready),
        .cmd        (cmd),
        .axis       (axis),
        .start_pos  (start_pos),
        .start_vel  (start_vel),
        .end_pos    (end_pos),
        .end_vel    (end_vel),
        .duration_ms(duration_ms),
        .time_ms    (time_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .vel_z      (vel_z)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint clamp_lim(longint a);
        if (a > LIM62)
            return LIM62;
        if (a < -LIM62)
            return -LIM62;
        return a;
    endfunction

    // round(a * r / 2^32), ties away from zero, magnitude saturated at 2^62.
    function automatic longint scale_by_ratio(longint a, logic [63:0] r);
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [127:0] res;
        neg = a < 0;
        mag = neg ? -a : a;
        prod = {64'd0, mag} * {64'd0, r};
        res = (prod + 128'h8000_0000) >> 32;
        if (res > 128'(LIM62))
            res = 128'(LIM62);
        return neg ? -longint'(res[63:0]) : longint'(res[63:0]);
    endfunction

    function automatic logic signed [31:0] to_q16(longint acc);
        logic        neg;
        logic [63:0] mag;
        neg = acc < 0;
        mag = neg ? -acc : acc;
        if (!neg && mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        if (neg && mag > 64'h8000_0000)
            mag = 64'h8000_0000;
        return neg ? -mag[31:0] : mag[31:0];
    endfunction

    // Solve one axis of the cubic and store it in velocity-vs-ratio form.
    task automatic apply_load();
        longint      p0;
        longint      pf;
        longint      v0;
        longint      vf;
        longint      delta;
        longint      quot;
        logic [63:0] num;
        logic [63:0] dur;
        logic [63:0] qmag;
        if (axis >= NUM_AXES)
            return;
        p0 = start_pos;
        pf = end_pos;
        v0 = start_vel;
        vf = end_vel;
        dur = (duration_ms == 0) ? 64'd1 : 64'(duration_ms);
        delta = pf - p0;
        num = (64'(SIX_K) * 64'(delta < 0 ? -delta : delta)) << FRAC;
        qmag = (2 * num + dur) / (2 * dur);
        quot = (delta < 0) ? -longint'(qmag) : longint'(qmag);
        axis_v0[axis] = start_vel;
        axis_dur[axis] = dur[15:0];
        axis_c2[axis] = quot - ((4 * v0 + 2 * vf) <<< FRAC);
        axis_c3[axis] = -quot + ((3 * (v0 + vf)) <<< FRAC);
    endtask

    function automatic logic signed [31:0] axis_velocity(int j, logic [15:0] t);
        logic [63:0] r;
        longint      inner;
        longint      acc;
        r = (axis_dur[j] == 0) ? 64'd0
            : ((64'(t) << 33) + 64'(axis_dur[j])) / (2 * 64'(axis_dur[j]));
        inner = clamp_lim(axis_c2[j] + scale_by_ratio(axis_c3[j], r));
        acc = clamp_lim((longint'(axis_v0[j]) <<< FRAC) + scale_by_ratio(inner, r));
        return to_q16(acc);
    endfunction

    // Send one transfer after a random gap; predict when it is accepted.
    // Returns at the falling edge after acceptance with valid still high, so
    // a following transfer can go out with no gap.
    task automatic send_item(logic c, logic [1:0] ax, logic [15:0] p0, logic [15:0] v0,
                             logic [15:0] pf, logic [15:0] vf, logic [15:0] dur,
                             logic [15:0] t);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        valid <= 1'b1;
        cmd <= c;
        axis <= ax;
        start_pos <= p0;
        start_vel <= v0;
        end_pos <= pf;
        end_vel <= vf;
        duration_ms <= dur;
        time_ms <= t;
        @(posedge clk);
        while (!ready) @(posedge clk);
        if (c == CMD_EVAL)
            sb.note_eval(axis_velocity(0, time_ms), axis_velocity(1, time_ms),
                         axis_velocity(2, time_ms));
        else
            apply_load();
        @(negedge clk);
    endtask

    task automatic send_load(logic [1:0] ax, logic [15:0] p0, logic [15:0] v0,
                             logic [15:0] pf, logic [15:0] vf, logic [15:0] dur);
        send_item(CMD_LOAD, ax, p0, v0, pf, vf, dur, 16'($urandom));
    endtask

    task automatic send_eval(logic [15:0] t);
        send_item(CMD_EVAL, 2'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), t);
    endtask

    function automatic logic [15:0] rand_small(int span);
        return 16'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // Result side: random stalls, check each accepted result.
    initial
    begin
        out_ready = 1'b0;
        wait (rx_enable);
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(vel_x, vel_y, vel_z);
        end
    end

    // Main stimulus.
    initial
    begin
        int          i;
        int          k;
        logic [15:0] dur;
        sb = new();
        stim_done = 1'b0;
        rx_enable = 1'b0;
        for (i = 0; i < NUM_AXES; i++)
        begin
            axis_v0[i] = 0;
            axis_dur[i] = 0;
            axis_c2[i] = 0;
            axis_c3[i] = 0;
        end
        rst_n = 1'b0;
        valid = 1'b0;
        cmd = CMD_LOAD;
        axis = 0;
        start_pos = 0;
        start_vel = 0;
        end_pos = 0;
        end_vel = 0;
        duration_ms = 0;
        time_ms = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        rx_enable = 1'b1;

        // Directed: never-loaded axes, then extremes and special cases.
        send_eval(16'd0);
        send_eval(16'hFFFF);
        send_load(2'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'd1);
        send_load(2'd1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_load(2'd2, 16'd100, 16'd10, 16'd500, 16'hFFF6, 16'd0);
        send_eval(16'd0);
        send_eval(16'd1);
        send_eval(16'hFFFF);
        // Out-of-range axis must leave the store untouched.
        send_load(2'd3, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'd5);
        send_eval(16'd1);
        send_load(2'd0, 16'd0, 16'd0, 16'd1000, 16'd0, 16'd1000);
        send_load(2'd1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd2);
        send_eval(16'd500);
        send_eval(16'd1000);
        send_eval(16'd3000);

        // Pause until the block has drained.
        valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);

        // Random: mostly plausible moves with small values, some full-range noise.
        for (k = 0; k < 1800; k++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_load(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
                else
                begin
                    dur = 16'($urandom_range(1, 5000));
                    send_load(2'($urandom_range(0, 2)), rand_small(2000), rand_small(300),
                              rand_small(2000), rand_small(300), dur);
                end
            end
            else if ($urandom_range(0, 7) == 0)
                send_eval(16'($urandom));
            else
                send_eval(16'($urandom_range(0, 5000)));
        end
        valid <= 1'b0;
        stim_done = 1'b1;
    end

    // End of run: drain, settle, report.
    initial
    begin
        wait (stim_done);
        while (sb.pending() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #50ms;
        $display("FAIL");
        $finish;
    end
endmodule

>>> files.f
rtl/core/ctv_pkg.sv
rtl/core/ctv_div.sv
rtl/core/ctv_mul.sv
rtl/core/cubic_trajectory_velocity.sv
verif/testbench.sv
